[rtl/two_pkg.sv]
// two_pkg: shared types, constants and tables for the tracking wheel odometry block
// no dependencies
`default_nettype none
package two_pkg;
   localparam int DistWidth  = 32;
   localparam int AngleIters = 16;
   localparam int HalfTurn   = 18000;
   localparam int FullTurn   = 36000;
   localparam int QuarterTurn = 9000;
   localparam logic [19:0] LeverK = 20'd749613;
   localparam logic signed [31:0] CordicGain = 32'sd652032874;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_SET    = 1'b1;
   localparam logic CSR_HOR_LEVER = 1'b0;
   localparam logic CSR_VER_LEVER = 1'b1;

   typedef struct packed {
      logic              mode;
      logic signed [31:0] hor_distance;
      logic signed [31:0] ver_distance;
      logic [15:0]       imu_heading;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic              load_x;
      logic              load_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading_folded;
   } rsp_type;

   typedef struct packed {
      logic              mode;
      logic signed [31:0] hor_distance;
      logic signed [31:0] ver_distance;
      logic signed [15:0] heading;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic              load_x;
      logic              load_y;
   } job_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      logic signed [31:0] r;
      begin
         case (i)
            5'd0: r = 294912000;  5'd1: r = 174096719; 5'd2: r = 91987925;
            5'd3: r = 46694507;   5'd4: r = 23437865;  5'd5: r = 11730358;
            5'd6: r = 5866610;    5'd7: r = 2933484;   5'd8: r = 1466764;
            5'd9: r = 733385;     5'd10: r = 366693;   5'd11: r = 183347;
            5'd12: r = 91673;     5'd13: r = 45837;    5'd14: r = 22918;
            5'd15: r = 11459;     5'd16: r = 5730;     5'd17: r = 2865;
            5'd18: r = 1432;      5'd19: r = 716;      5'd20: r = 358;
            5'd21: r = 179;       5'd22: r = 90;       5'd23: r = 45;
            default: r = 0;
         endcase
         atan_entry = r;
      end
   endfunction
endpackage
`default_nettype wire

[rtl/two_front.sv]
// two_front: accepts transactions, folds the heading, two-entry queue to the back end
// depends on two_pkg
`default_nettype none
module two_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire two_pkg::req_type  req_data,
   output logic                   job_valid,
   input  wire logic              job_take,
   output two_pkg::job_type       job_data
);
   two_pkg::job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;
   logic [16:0] h_raw, h_red;
   logic signed [16:0] h_fold;
   two_pkg::job_type new_job;

   always_comb begin
      h_raw = {1'b0, req_data.imu_heading};
      h_red = (h_raw >= 17'(two_pkg::FullTurn)) ? h_raw - 17'(two_pkg::FullTurn) : h_raw;
      h_fold = (h_red > 17'(two_pkg::HalfTurn)) ? $signed(h_red - 17'(two_pkg::FullTurn))
                                                : $signed(h_red);
      new_job.mode = req_data.mode;
      new_job.hor_distance = req_data.hor_distance;
      new_job.ver_distance = req_data.ver_distance;
      new_job.heading = h_fold[15:0];
      new_job.new_x = req_data.new_x;
      new_job.new_y = req_data.new_y;
      new_job.load_x = req_data.load_x;
      new_job.load_y = req_data.load_y;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_take;
   assign job_data = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) q_ff[wr_ff] <= new_job;
   end
endmodule
`default_nettype wire

[rtl/two_back.sv]
// two_back: sequencer for lever correction, cordic, pose update; products on one multiplier
// depends on two_pkg
`default_nettype none
module two_back #(
   parameter int DIST_WIDTH  = two_pkg::DistWidth,
   parameter int ANGLE_ITERS = two_pkg::AngleIters
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic signed [14:0] csr_lever,
   input  wire logic              job_valid,
   output logic                   job_take,
   input  wire two_pkg::job_type  job_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output two_pkg::rsp_type       rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_DELTA, S_LEV0, S_LEV1, S_LEV2, S_LEV3, S_CORDIC,
      S_M0, S_M1, S_M2, S_M3, S_SUM, S_OUT
   } state_type;

   localparam int CntW = $clog2(ANGLE_ITERS + 1);
   // multiplier operand width: distance delta plus lever correction, at least 32
   localparam int MulW = (DIST_WIDTH + 2 > 32) ? DIST_WIDTH + 2 : 32;

   state_type state_ff;
   logic signed [14:0] hlev_ff, vlev_ff;
   logic signed [31:0] prev_hor_ff, prev_ver_ff, acc_x_ff, acc_y_ff;
   logic signed [15:0] prev_head_ff;
   two_pkg::job_type   job_ff;
   logic signed [16:0] dh_ff;
   logic [63:0] dx_ff, dy_ff, p_ff, tx_ff, ty_ff;
   logic signed [63:0] cx_ff, cy_ff, cz_ff;
   logic        neg_ff;
   logic [CntW-1:0] it_ff;
   logic rsp_valid_ff;
   two_pkg::rsp_type rsp_ff;

   logic signed [16:0] dh_raw, dh_w;
   logic signed [31:0] h_adj;
   logic signed [DIST_WIDTH-1:0] dhor_w, dver_w;
   logic signed [63:0] xs, ys, at;
   logic [63:0] sin_u, cos_u, prod;
   logic signed [MulW-1:0] ma;
   logic signed [31:0] mb;
   logic signed [MulW+31:0] prod_full;
   logic [63:0] lever_t;

   assign job_take = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      dh_raw = 17'(job_ff.heading) - 17'(prev_head_ff);
      if (dh_raw > 17'sd18000) dh_w = dh_raw - 17'sd36000;
      else if (dh_raw < -17'sd18000) dh_w = dh_raw + 17'sd36000;
      else dh_w = dh_raw;
      dhor_w = DIST_WIDTH'(job_ff.hor_distance - prev_hor_ff);
      dver_w = DIST_WIDTH'(job_ff.ver_distance - prev_ver_ff);
      xs = cx_ff >>> it_ff;
      ys = cy_ff >>> it_ff;
      at = 64'(two_pkg::atan_entry(5'(it_ff)));
      sin_u = neg_ff ? -cy_ff : cy_ff;
      cos_u = neg_ff ? -cx_ff : cx_ff;
      case (state_ff)
         S_LEV0, S_LEV2: begin
            ma = MulW'(dh_ff);
            mb = (state_ff == S_LEV0) ? 32'(hlev_ff) : 32'(vlev_ff);
         end
         S_LEV1, S_LEV3: begin ma = MulW'(p_ff); mb = 32'(two_pkg::LeverK); end
         S_M0: begin ma = MulW'(dy_ff); mb = 32'(sin_u); end
         S_M1: begin ma = MulW'(dx_ff); mb = 32'(cos_u); end
         S_M2: begin ma = MulW'(dy_ff); mb = 32'(cos_u); end
         S_M3: begin ma = MulW'(dx_ff); mb = 32'(sin_u); end
         default: begin ma = '0; mb = '0; end
      endcase
      prod_full = ma * mb;
      prod = prod_full[63:0];
      lever_t = prod + 64'h8000_0000;
      h_adj = 32'(job_ff.heading);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hlev_ff <= '0;
         vlev_ff <= '0;
         prev_hor_ff <= '0;
         prev_ver_ff <= '0;
         prev_head_ff <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == two_pkg::CSR_HOR_LEVER) hlev_ff <= csr_lever;
            else vlev_ff <= csr_lever;
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (job_valid && !rsp_valid_ff) begin
               job_ff <= job_data;
               state_ff <= S_DELTA;
            end
            S_DELTA: begin
               if (job_ff.mode == two_pkg::MODE_SET) begin
                  if (job_ff.load_x) acc_x_ff <= job_ff.new_x;
                  if (job_ff.load_y) acc_y_ff <= job_ff.new_y;
                  state_ff <= S_OUT;
               end else begin
                  dh_ff <= dh_w;
                  dx_ff <= 64'(dhor_w);
                  dy_ff <= 64'(dver_w);
                  cx_ff <= 64'(two_pkg::CordicGain);
                  cy_ff <= '0;
                  it_ff <= '0;
                  if (h_adj > two_pkg::QuarterTurn) begin
                     cz_ff <= 64'(h_adj - two_pkg::HalfTurn) <<< 16; neg_ff <= 1'b1;
                  end else if (h_adj < -two_pkg::QuarterTurn) begin
                     cz_ff <= 64'(h_adj + two_pkg::HalfTurn) <<< 16; neg_ff <= 1'b1;
                  end else begin
                     cz_ff <= 64'(h_adj) <<< 16; neg_ff <= 1'b0;
                  end
                  state_ff <= S_LEV0;
               end
            end
            S_LEV0: begin p_ff <= prod; state_ff <= S_LEV1; end
            S_LEV1: begin
               dx_ff <= dx_ff + {{32{lever_t[63]}}, lever_t[63:32]};
               state_ff <= S_LEV2;
            end
            S_LEV2: begin p_ff <= prod; state_ff <= S_LEV3; end
            S_LEV3: begin
               dy_ff <= dy_ff + {{32{lever_t[63]}}, lever_t[63:32]};
               state_ff <= S_CORDIC;
            end
            S_CORDIC: begin
               if (it_ff == CntW'(ANGLE_ITERS)) begin
                  state_ff <= S_M0;
               end else begin
                  if (!cz_ff[63]) begin
                     cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs; cz_ff <= cz_ff - at;
                  end else begin
                     cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs; cz_ff <= cz_ff + at;
                  end
                  it_ff <= it_ff + 1'b1;
               end
            end
            S_M0: begin tx_ff <= prod + 64'h2000_0000; state_ff <= S_M1; end
            S_M1: begin tx_ff <= tx_ff - prod; state_ff <= S_M2; end
            S_M2: begin ty_ff <= prod + 64'h2000_0000; state_ff <= S_M3; end
            S_M3: begin ty_ff <= ty_ff + prod; state_ff <= S_SUM; end
            S_SUM: begin
               acc_x_ff <= acc_x_ff + tx_ff[61:30];
               acc_y_ff <= acc_y_ff + ty_ff[61:30];
               prev_hor_ff <= job_ff.hor_distance;
               prev_ver_ff <= job_ff.ver_distance;
               prev_head_ff <= job_ff.heading;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_ff.pos_x <= acc_x_ff;
               rsp_ff.pos_y <= acc_y_ff;
               rsp_ff.heading_folded <= prev_head_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[rtl/tracking_wheel_odometry.sv]
// tracking_wheel_odometry: top level, front end queue feeding the pose sequencer
// depends on two_pkg, two_front, two_back
//
// channel  direction  payload
// req      in         two_pkg::req_type
// rsp      out        two_pkg::rsp_type
// csr      in         lever arm write, index 0 horizontal, 1 vertical
//
// a sample transaction runs the back end through S_DELTA, S_LEV0 to S_LEV3, S_CORDIC,
// S_M0 to S_M3, S_SUM and S_OUT on one shared multiplier; set pose runs S_DELTA, S_OUT
// synchronous reset clears pose, previous sample and lever arms
// the front queue holds two transactions while the result register waits on rsp_stall
`default_nettype none
module tracking_wheel_odometry #(
   parameter int DIST_WIDTH  = two_pkg::DistWidth,
   parameter int ANGLE_ITERS = two_pkg::AngleIters
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire two_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output two_pkg::rsp_type       rsp_data,
   input  wire logic              csr_write,
   input  wire logic [0:0]        csr_index,
   input  wire logic [14:0]       csr_data
);
   logic             job_valid, job_take;
   two_pkg::job_type job_data;

   two_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .job_valid, .job_take, .job_data
   );

   two_back #(.DIST_WIDTH(DIST_WIDTH), .ANGLE_ITERS(ANGLE_ITERS)) u_back (
      .clock, .reset, .csr_write,
      .csr_index(csr_index[0]), .csr_lever($signed(csr_data)),
      .job_valid, .job_take, .job_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

[verif/odometry_checker.sv]
// odometry_checker: watches the req, rsp and csr ports of tracking_wheel_odometry,
// predicts each pose result and compares it field by field; depends on two_pkg
`timescale 1ns / 100ps
`default_nettype none
module odometry_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire two_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire two_pkg::rsp_type rsp_data,
   input  wire logic             csr_write,
   input  wire logic [0:0]       csr_index,
   input  wire logic [14:0]      csr_data,
   output int                    mismatches,
   output int                    poses_pending,
   output int                    poses_seen
);
   localparam longint ArcTable[24] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358, 5866610, 2933484,
      1466764, 733385, 366693, 183347, 91673, 45837, 22918, 11459,
      5730, 2865, 1432, 716, 358, 179, 90, 45};

   logic [14:0]        hor_arm, ver_arm;
   logic signed [31:0] last_hor, last_ver, pose_x, pose_y;
   int                 last_heading;
   two_pkg::rsp_type   pose_queue[$];

   function automatic void heading_sincos(input int h, output longint s, output longint c);
      longint x, y, z, nx;
      bit     flip;
      x = two_pkg::CordicGain;
      y = 0;
      flip = 0;
      if (h > two_pkg::QuarterTurn) begin
         h -= two_pkg::HalfTurn;
         flip = 1;
      end else if (h < -two_pkg::QuarterTurn) begin
         h += two_pkg::HalfTurn;
         flip = 1;
      end
      z = longint'(h) * 65536;
      for (int i = 0; i < two_pkg::AngleIters; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ArcTable[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ArcTable[i];
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint lever_term(input int dh, input logic [14:0] arm);
      longint    p;
      bit [63:0] t;
      p = longint'(dh) * longint'($signed(arm));
      t = p * 64'd749613 + 64'h8000_0000;
      return longint'($signed(t[63:32]));
   endfunction

   function automatic two_pkg::rsp_type next_pose(input two_pkg::req_type r);
      int                 h, dh;
      logic signed [31:0] dhor, dver;
      longint             s, c;
      bit [63:0]          dx, dy, tx, ty;
      two_pkg::rsp_type   p;
      if (r.mode == two_pkg::MODE_SET) begin
         if (r.load_x) pose_x = r.new_x;
         if (r.load_y) pose_y = r.new_y;
      end else begin
         h = int'(r.imu_heading) % two_pkg::FullTurn;
         if (h > two_pkg::HalfTurn) h -= two_pkg::FullTurn;
         dh = h - last_heading;
         if (dh > two_pkg::HalfTurn) dh -= two_pkg::FullTurn;
         else if (dh < -two_pkg::HalfTurn) dh += two_pkg::FullTurn;
         dhor = r.hor_distance - last_hor;
         dver = r.ver_distance - last_ver;
         dx = longint'(dhor) + lever_term(dh, hor_arm);
         dy = longint'(dver) + lever_term(dh, ver_arm);
         heading_sincos(h, s, c);
         tx = dy * s - dx * c + (64'd1 << 29);
         ty = dy * c + dx * s + (64'd1 << 29);
         pose_x = pose_x + tx[61:30];
         pose_y = pose_y + ty[61:30];
         last_hor = r.hor_distance;
         last_ver = r.ver_distance;
         last_heading = h;
      end
      p.pos_x = pose_x;
      p.pos_y = pose_y;
      p.heading_folded = last_heading[15:0];
      return p;
   endfunction

   always @(posedge clock) begin
      two_pkg::rsp_type want;
      if (reset) begin
         hor_arm <= '0;
         ver_arm <= '0;
         last_hor = '0;
         last_ver = '0;
         last_heading = 0;
         pose_x = '0;
         pose_y = '0;
         pose_queue.delete();
         mismatches <= 0;
         poses_seen <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == two_pkg::CSR_HOR_LEVER) hor_arm <= csr_data;
            else ver_arm <= csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            poses_seen <= poses_seen + 1;
            if (pose_queue.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("%t unexpected rsp transaction %p", $realtime, rsp_data);
            end else begin
               want = pose_queue.pop_front();
               if (rsp_data.pos_x !== want.pos_x || rsp_data.pos_y !== want.pos_y ||
                   rsp_data.heading_folded !== want.heading_folded) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("%t rsp mismatch: expected x %0d y %0d h %0d, got x %0d y %0d h %0d",
                              $realtime, want.pos_x, want.pos_y, want.heading_folded,
                              rsp_data.pos_x, rsp_data.pos_y, rsp_data.heading_folded);
               end
            end
         end
         if (req_valid && !req_stall) pose_queue.push_back(next_pose(req_data));
      end
      poses_pending <= pose_queue.size();
   end
endmodule
`default_nettype wire

[verif/tb_top.sv]
// tb_top: stimulus and verdict for tracking_wheel_odometry
// depends on two_pkg, the rtl and odometry_checker
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   two_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   two_pkg::rsp_type rsp_data;
   logic             csr_write = 0;
   logic [0:0]       csr_index = '0;
   logic [14:0]      csr_data = '0;
   int          mismatches, poses_pending, poses_seen;
   bit          calm = 0;
   bit          held = 0;
   int          hold_left = 0;
   int          sample_count = 0, set_count = 0;
   logic signed [31:0] travel_h = 0, travel_v = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   tracking_wheel_odometry i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_data);

   odometry_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_data,
      .mismatches, .poses_pending, .poses_seen);

   // receiver: random stalls, one long hold to back up the pipeline
   always @(posedge clock) begin
      if (!reset && !held && poses_seen == 120) begin
         held <= 1;
         hold_left <= 300;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !calm && $urandom_range(99) < 33;
      end
   end

   task automatic send(input two_pkg::req_type r);
      while (!calm && $urandom_range(99) < 33) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      if (r.mode == two_pkg::MODE_SET) set_count++;
      else sample_count++;
   endtask

   task automatic sample(input logic signed [31:0] h, input logic signed [31:0] v,
                         input logic [15:0] hd);
      two_pkg::req_type r;
      r = '0;
      r.mode = two_pkg::MODE_SAMPLE;
      r.hor_distance = h;
      r.ver_distance = v;
      r.imu_heading = hd;
      r.new_x = $urandom;
      r.new_y = $urandom;
      r.load_x = 1'($urandom_range(1));
      r.load_y = 1'($urandom_range(1));
      send(r);
   endtask

   task automatic set_pose(input logic lx, input logic ly,
                           input logic signed [31:0] x, input logic signed [31:0] y);
      two_pkg::req_type r;
      r = '0;
      r.mode = two_pkg::MODE_SET;
      r.hor_distance = $urandom;
      r.ver_distance = $urandom;
      r.imu_heading = 16'($urandom);
      r.new_x = x;
      r.new_y = y;
      r.load_x = lx;
      r.load_y = ly;
      send(r);
   endtask

   task automatic settle_and_write(input logic [14:0] hor, input logic [14:0] ver);
      req_valid <= 0;
      @(posedge clock);
      wait (poses_pending == 0);
      repeat (40) @(posedge clock);
      csr_write <= 1;
      csr_index <= two_pkg::CSR_HOR_LEVER;
      csr_data <= hor;
      @(posedge clock);
      csr_index <= two_pkg::CSR_VER_LEVER;
      csr_data <= ver;
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic random_items(input int count, input int calm_from, input int calm_to);
      logic [15:0] hd;
      for (int i = 0; i < count; i++) begin
         calm = i >= calm_from && i < calm_to;
         if ($urandom_range(99) < 10) begin
            set_pose(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom);
         end else begin
            if ($urandom_range(99) < 8) begin
               travel_h = $urandom;
               travel_v = $urandom;
            end else begin
               travel_h += $signed($urandom_range(8000)) - 4000;
               travel_v += $signed($urandom_range(8000)) - 4000;
            end
            hd = $urandom_range(99) < 5 ? 16'($urandom) : 16'($urandom_range(35999));
            sample(travel_h, travel_v, hd);
         end
      end
      calm = 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes of heading and distance, set-pose variants
      sample(32'sd0, 32'sd0, 16'd0);
      sample(32'sd2560, -32'sd2560, 16'd9000);
      sample(32'sd2560, 32'sd5120, 16'd9001);
      sample(32'h7fffffff, 32'h80000000, 16'd18000);
      sample(32'h80000000, 32'h7fffffff, 16'd18001);
      sample(32'h7fffffff, 32'h80000000, 16'd35999);
      sample(32'sd100, 32'sd100, 16'd17999);
      sample(-32'sd1, -32'sd1, 16'd27000);
      sample(32'sd1000, 32'sd1000, 16'd36000);
      sample(32'sd2000, -32'sd3000, 16'hffff);
      set_pose(1, 0, 32'h7fffffff, 32'sd5);
      set_pose(0, 1, 32'sd7, 32'h80000000);
      set_pose(0, 0, 32'hffffffff, 32'hffffffff);
      sample(32'sd4000, 32'sd4000, 16'd100);
      set_pose(1, 1, 32'h7fffff00, 32'h800000ff);
      sample(32'sd90000, 32'sd90000, 16'd4500);
      settle_and_write(15'h3fff, 15'h4000);
      sample(32'sd90000, 32'sd91000, 16'd22000);
      sample(32'sd90500, 32'sd91000, 16'd4000);
      sample(32'sd91000, 32'sd91200, 16'd35999);
      random_items(90, 30, 80);
      settle_and_write(15'h4000, 15'h3fff);
      sample(32'sd0, 32'sd0, 16'd18000);
      sample(32'sd256, 32'sd256, 16'd0);
      random_items(90, 200, 200);
      settle_and_write(15'($urandom), 15'($urandom));
      random_items(90, 20, 70);
      settle_and_write(15'd0, 15'd0);
      random_items(60, 200, 200);
      settle_and_write(15'd700, -15'sd300);
      random_items(60, 10, 40);
      req_valid <= 0;
      @(posedge clock);
      wait (poses_pending == 0);
      repeat (40) @(posedge clock);
      $display("covered %0d samples and %0d set-pose transactions, %0d poses checked",
               sample_count, set_count, poses_seen);
      $display("lever arms swept through zero, both extremes and random values");
      if (mismatches == 0 && poses_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d poses outstanding", poses_pending);
      $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
rtl/two_pkg.sv
rtl/two_front.sv
rtl/two_back.sv
rtl/tracking_wheel_odometry.sv
verif/odometry_checker.sv
verif/tb_top.sv
